@@ design/jase_pkg.sv @@
// ----------------------------------------------------------------------------
// JSON ASCII string escaper package
// Shared types, character codes and helper functions for the escaper.
// ----------------------------------------------------------------------------
package jase_pkg;

  // Character codes that the escaper looks for or produces.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // UTF-8 decoding constants.
  localparam logic [7:0]  UTF_LEAD2    = 8'hE0;
  localparam logic [7:0]  UTF_LEAD3    = 8'hF0;
  localparam logic [1:0]  UTF_CONT_TAG = 2'b10;
  localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;
  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE = 16'hDC00;

  // Kind of output sequence that one input byte produces.
  typedef enum logic [2:0] {
    JOB_CHAR, // one plain byte
    JOB_PAIR, // backslash and one letter
    JOB_U4,   // one \uxxxx escape
    JOB_U8,   // surrogate pair, two \uxxxx escapes
    JOB_ERR   // single error result
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  ch;   // plain byte or escape letter
    logic [15:0] hi;   // first (or only) 16-bit value of a \u escape
    logic [15:0] lo;   // second half of a surrogate pair
    logic        eot;  // the byte closed the text
  } job_t;

  // Number of result bytes of a job.
  function automatic logic [3:0] job_len(job_kind_e kind);
    logic [3:0] len;
    unique case (kind)
      JOB_CHAR: len = 4'd1;
      JOB_PAIR: len = 4'd2;
      JOB_U4:   len = 4'd6;
      JOB_U8:   len = 4'd12;
      JOB_ERR:  len = 4'd1;
      default:  len = 4'd1;
    endcase
    return len;
  endfunction

  // Lowercase hex digit of a nibble.
  function automatic logic [7:0] hex_digit(logic [3:0] nib);
    logic [7:0] dig;
    if (nib < 4'd10) begin
      dig = 8'h30 + {4'h0, nib};
    end else begin
      dig = 8'h57 + {4'h0, nib};
    end
    return dig;
  endfunction

endpackage

@@ design/jase_in_if.sv @@
// ----------------------------------------------------------------------------
// Escaper input channel
// Valid/ready channel carrying one raw UTF-8 byte per request.
// ----------------------------------------------------------------------------
interface jase_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

@@ design/jase_out_if.sv @@
// ----------------------------------------------------------------------------
// Escaper output channel
// Valid/ready channel carrying one escaped ASCII byte per request.
// ----------------------------------------------------------------------------
interface jase_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, output out_byte, output last, output error, input ready);
  modport sink   (input valid, input out_byte, input last, input error, output ready);
endinterface

@@ design/json_ascii_string_escaper_top.sv @@
// The escaper takes UTF-8 text one byte per request and returns its JSON,
// ASCII-only escaped form one byte per request, with last marking the final
// byte of each text and error (with a zero byte and last) reporting malformed
// UTF-8, after which the rest of that text is dropped. A byte that yields one
// result (plain ASCII) is accepted every cycle while the sink is ready; a byte
// whose escape expands to N result bytes (2 for short escapes, 6 for \uxxxx,
// 12 for a surrogate pair) holds the input while the emitter writes them into
// the output register one byte per cycle as the sink takes them. Bytes that
// yield no result (lead and inner continuation bytes, skipped bytes) are
// accepted one per cycle while the job register is free. The output register
// lets the next byte be taken while a result waits on a stalled sink.

// ----------------------------------------------------------------------------
// JSON ASCII string escaper top level
// Decoder stage with the UTF-8 state and job register, followed by the
// emitter stage with the output register.
// ----------------------------------------------------------------------------
module json_ascii_string_escaper_top import jase_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  jase_in_if.sink    in_i,
  jase_out_if.source out_o
);

  // The job register sits between the two stages. A job leaves it when the
  // emitter loads its final byte, and that same cycle frees the decoder to
  // accept the next input byte.
  job_t       job;
  logic       job_valid;
  logic       job_taken;
  logic [3:0] emit_idx;

  jase_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_taken_i (job_taken),
    .job_o       (job),
    .job_valid_o (job_valid)
  );

  jase_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_taken_o (job_taken),
    .idx_o       (emit_idx),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // An error result is always a zero byte that closes the text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.error |-> out_o.last && (out_o.out_byte == CH_NUL))
    else $error("error result without last or with nonzero byte");

  // The emitter position never runs past the length of the pending job.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |-> (emit_idx < job_len(job.kind)))
    else $error("emitter index beyond job length");

  // A job is only retired while one is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_taken |-> job_valid)
    else $error("job retired with no job pending");

  // Between jobs the emitter position is back at the start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_taken |=> (emit_idx == 4'd0))
    else $error("emitter index not cleared after a job");
`endif

endmodule

@@ design/jase_decode.sv @@
// ----------------------------------------------------------------------------
// Escaper byte decoder
// Classifies each accepted byte, tracks UTF-8 decoding state and registers
// the resulting output job.
// ----------------------------------------------------------------------------
module jase_decode import jase_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  jase_in_if.sink in_i,
  input  logic   job_taken_i,
  output job_t   job_o,
  output logic   job_valid_o
);

  logic [20:0] acc_q, acc_d;
  logic [1:0]  rem_q, rem_d;
  logic        skip_q, skip_d;
  job_t        job_q, job_d;
  logic        job_valid_q;
  logic        new_job;
  logic        accept;
  logic [7:0]  b;
  logic        eot;
  logic [20:0] acc_shift;
  logic [20:0] supp;

  assign in_i.ready  = !job_valid_q || job_taken_i;
  assign accept      = in_i.valid && in_i.ready;
  assign job_o       = job_q;
  assign job_valid_o = job_valid_q;

  assign b         = in_i.in_byte;
  assign eot       = in_i.end_of_text;
  assign acc_shift = {acc_q[14:0], b[5:0]};
  assign supp      = acc_shift - SUPP_BASE;

  always_comb begin
    acc_d       = acc_q;
    rem_d       = rem_q;
    skip_d      = skip_q;
    new_job     = 1'b0;
    job_d.kind  = JOB_CHAR;
    job_d.ch    = b;
    job_d.hi    = {8'h00, b};
    job_d.lo    = 16'h0000;
    job_d.eot   = eot;

    if (skip_q) begin
      // Discard the rest of an aborted text.
      if (eot) begin
        skip_d = 1'b0;
      end
    end else if (rem_q == 2'd0) begin
      new_job = 1'b1;
      unique case (b) inside
        CH_QUOTE, CH_BSLASH: begin
          job_d.kind = JOB_PAIR;
        end
        CH_BS: begin
          job_d.kind = JOB_PAIR;
          job_d.ch   = CH_B;
        end
        CH_TAB: begin
          job_d.kind = JOB_PAIR;
          job_d.ch   = CH_T;
        end
        CH_LF: begin
          job_d.kind = JOB_PAIR;
          job_d.ch   = CH_N;
        end
        CH_FF: begin
          job_d.kind = JOB_PAIR;
          job_d.ch   = CH_F;
        end
        CH_CR: begin
          job_d.kind = JOB_PAIR;
          job_d.ch   = CH_R;
        end
        CH_LT, CH_GT, CH_AMP, CH_APOS: begin
          job_d.kind = JOB_U4;
        end
        default: begin
          if (b < CH_SPACE || b == CH_DEL) begin
            job_d.kind = JOB_U4;
          end else if (!b[7]) begin
            job_d.kind = JOB_CHAR;
          end else begin
            // Lead byte of a multibyte sequence.
            new_job = 1'b0;
            if (b < UTF_LEAD2) begin
              rem_d = 2'd1;
              acc_d = {16'h0000, b[4:0]};
            end else if (b < UTF_LEAD3) begin
              rem_d = 2'd2;
              acc_d = {17'h00000, b[3:0]};
            end else begin
              rem_d = 2'd3;
              acc_d = {18'h00000, b[2:0]};
            end
            if (eot) begin
              new_job    = 1'b1;
              job_d.kind = JOB_ERR;
              acc_d      = '0;
              rem_d      = 2'd0;
            end
          end
        end
      endcase
    end else begin
      if (b[7:6] != UTF_CONT_TAG) begin
        new_job    = 1'b1;
        job_d.kind = JOB_ERR;
        acc_d      = '0;
        rem_d      = 2'd0;
        skip_d     = !eot;
      end else begin
        acc_d = acc_shift;
        rem_d = rem_q - 2'd1;
        if (rem_q != 2'd1) begin
          if (eot) begin
            new_job    = 1'b1;
            job_d.kind = JOB_ERR;
            acc_d      = '0;
            rem_d      = 2'd0;
          end
        end else begin
          new_job = 1'b1;
          acc_d   = '0;
          if (acc_shift <= BMP_MAX) begin
            job_d.kind = JOB_U4;
            job_d.hi   = acc_shift[15:0];
          end else begin
            job_d.kind = JOB_U8;
            job_d.hi   = SURR_HI_BASE + {5'h00, supp[20:10]};
            job_d.lo   = SURR_LO_BASE + {6'h00, supp[9:0]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      rem_q       <= 2'd0;
      skip_q      <= 1'b0;
      job_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        acc_q       <= acc_d;
        rem_q       <= rem_d;
        skip_q      <= skip_d;
        job_valid_q <= new_job;
      end else if (job_taken_i) begin
        job_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && new_job) begin
      job_q <= job_d;
    end
  end

endmodule

@@ design/jase_emit.sv @@
// ----------------------------------------------------------------------------
// Escaper byte emitter
// Steps through the bytes of the pending job and fills the output register.
// ----------------------------------------------------------------------------
module jase_emit import jase_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       job_valid_i,
  output logic       job_taken_o,
  output logic [3:0] idx_o,
  jase_out_if.source out_o
);

  logic [3:0]  idx_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        last_q;
  logic        error_q;
  logic        load;
  logic        final_byte;
  logic        second;
  logic [3:0]  pos;
  logic [15:0] val;
  logic [7:0]  byte_d;

  assign load        = job_valid_i && (!out_valid_q || out_o.ready);
  assign final_byte  = (idx_q == job_len(job_i.kind) - 4'd1);
  assign job_taken_o = load && final_byte;
  assign idx_o       = idx_q;

  // Position inside the current \uxxxx escape and the value it spells.
  assign second = (idx_q >= 4'd6);
  assign pos    = second ? idx_q - 4'd6 : idx_q;
  assign val    = second ? job_i.lo : job_i.hi;

  always_comb begin
    byte_d = CH_NUL;
    unique case (job_i.kind)
      JOB_CHAR: byte_d = job_i.ch;
      JOB_PAIR: byte_d = (idx_q == 4'd0) ? CH_BSLASH : job_i.ch;
      JOB_U4, JOB_U8: begin
        case (pos)
          4'd0:    byte_d = CH_BSLASH;
          4'd1:    byte_d = CH_U;
          4'd2:    byte_d = hex_digit(val[15:12]);
          4'd3:    byte_d = hex_digit(val[11:8]);
          4'd4:    byte_d = hex_digit(val[7:4]);
          4'd5:    byte_d = hex_digit(val[3:0]);
          default: byte_d = CH_NUL;
        endcase
      end
      JOB_ERR: byte_d = CH_NUL;
      default: byte_d = CH_NUL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= final_byte ? 4'd0 : idx_q + 4'd1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_d;
      error_q    <= (job_i.kind == JOB_ERR);
      last_q     <= (job_i.kind == JOB_ERR) || (job_i.eot && final_byte);
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last     = last_q;
  assign out_o.error    = error_q;

endmodule
